// ===== hw/rtl/clcd_pkg.sv =====
// Package for the character display writer: operation codes, frame types and the
// Cyrillic glyph table. It depends on nothing else.
package clcd_pkg;

  typedef enum logic [2:0] {
    KIND_CHAR  = 3'd0,
    KIND_CMD   = 3'd1,
    KIND_PLACE = 3'd2,
    KIND_CLEAR = 3'd3,
    KIND_INIT  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    LEAD_NONE = 2'd0,
    LEAD_D0   = 2'd1,
    LEAD_D1   = 2'd2
  } lead_e;

  localparam logic [7:0] LEAD_BYTE_D0 = 8'hD0;
  localparam logic [7:0] LEAD_BYTE_D1 = 8'hD1;
  localparam logic [7:0] CONT_LOW     = 8'h80;
  localparam logic [7:0] CONT_END     = 8'hC0;
  localparam logic [7:0] GLYPH_YO_UP  = 8'hA2;
  localparam logic [7:0] GLYPH_YO_LOW = 8'hB5;
  localparam logic [5:0] IDX_YO_UP    = 6'h01;
  localparam logic [5:0] IDX_YO_LOW   = 6'h11;
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_INIT_A   = 8'h30;
  localparam logic [7:0] CMD_INIT_B   = 8'h02;
  localparam logic [7:0] CMD_INIT_C   = 8'h0C;
  localparam logic [7:0] LINE1_OFFSET = 8'h40;

  localparam logic [7:0] CYR_MAP [64] = '{
    8'h70, 8'h63, 8'hbf, 8'h79, 8'he4, 8'h78, 8'he5, 8'hc0, 8'hc1, 8'he6, 8'hc2, 8'hc3,
    8'hc4, 8'hc5, 8'hc6, 8'hc7, 8'h41, 8'ha0, 8'h42, 8'ha1, 8'he0, 8'h45, 8'ha3, 8'ha4,
    8'ha5, 8'ha6, 8'h4b, 8'ha7, 8'h4d, 8'h48, 8'h4f, 8'ha8, 8'h50, 8'h43, 8'h54, 8'ha9,
    8'haa, 8'h58, 8'he1, 8'hab, 8'hac, 8'he2, 8'had, 8'hae, 8'h62, 8'haf, 8'hb0, 8'hb1,
    8'h61, 8'hb2, 8'hb3, 8'hb4, 8'he3, 8'h65, 8'hb6, 8'hb7, 8'hb8, 8'hb9, 8'hba, 8'hbb,
    8'hbc, 8'hbd, 8'h6f, 8'hbe
  };

  typedef struct packed {
    logic [7:0] data;
    logic       rs;
  } frame_t;

  typedef struct packed {
    frame_t [3:0] frm;
    logic [2:0]   count;
  } plan_t;

endpackage

// ===== hw/rtl/clcd_planner.sv =====
// Decodes one operation into up to four controller bytes and keeps the cursor and
// UTF-8 lead state. Depends on clcd_pkg.
module clcd_planner #(
  parameter int COLUMNS = 20,
  parameter int LINES   = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [2:0]     kind_i,
  input  logic [7:0]     value_i,
  input  logic [5:0]     column_i,
  input  logic [2:0]     row_i,
  output clcd_pkg::plan_t plan_o
);
  import clcd_pkg::*;

  typedef struct packed {
    logic [5:0] col;
    logic [1:0] line;
    logic       wrap;
    logic [7:0] cmd;
  } cur_t;

  lead_e      lead_q, lead_d;
  logic [5:0] col_q, col_d;
  logic [1:0] line_q, line_d;

  function automatic logic [7:0] addr_cmd(input logic [5:0] col, input logic [1:0] line);
    logic [7:0] off;
    off = (line[0] ? LINE1_OFFSET : 8'h00) + (line[1] ? 8'(COLUMNS) : 8'h00);
    return CMD_SET_ADDR | (8'(col) + off);
  endfunction

  function automatic cur_t show_fn(input logic [5:0] col, input logic [1:0] line);
    cur_t r;
    r.col  = col + 6'd1;
    r.line = line;
    r.wrap = 1'b0;
    r.cmd  = 8'h00;
    if (({1'b0, col} + 7'd1) >= 7'(COLUMNS)) begin
      r.col  = 6'd0;
      r.wrap = 1'b1;
      if (({1'b0, line} + 3'd1) >= 3'(LINES)) begin
        r.line = 2'd0;
      end else begin
        r.line = line + 2'd1;
      end
      r.cmd = addr_cmd(6'd0, r.line);
    end
    return r;
  endfunction

  always_comb begin
    cur_t       s1;
    cur_t       s2;
    logic [2:0] n;
    logic [7:0] lead_byte;
    logic [7:0] glyph;
    logic [2:0] row_c;
    plan_o  = '0;
    lead_d  = lead_q;
    col_d   = col_q;
    line_d  = line_q;
    n       = 3'd0;
    s1      = '0;
    s2      = '0;
    lead_byte = (lead_q == LEAD_D1) ? LEAD_BYTE_D1 : LEAD_BYTE_D0;
    glyph   = CYR_MAP[value_i[5:0]];
    row_c   = (row_i >= 3'(LINES)) ? 3'(LINES - 1) : row_i;
    unique case (kind_i)
      KIND_CHAR: begin
        if (lead_q != LEAD_NONE) begin
          lead_d = LEAD_NONE;
          if (value_i >= CONT_END || value_i < CONT_LOW) begin
            s1 = show_fn(col_q, line_q);
            s2 = show_fn(s1.col, s1.line);
            plan_o.frm[0] = '{data: lead_byte, rs: 1'b1};
            n = 3'd1;
            if (s1.wrap) begin
              plan_o.frm[1] = '{data: s1.cmd, rs: 1'b0};
              n = 3'd2;
            end
            plan_o.frm[n[1:0]] = '{data: value_i, rs: 1'b1};
            n = n + 3'd1;
            if (s2.wrap) begin
              plan_o.frm[n[1:0]] = '{data: s2.cmd, rs: 1'b0};
              n = n + 3'd1;
            end
            col_d  = s2.col;
            line_d = s2.line;
          end else begin
            if (lead_q == LEAD_D0 && value_i[5:0] == IDX_YO_UP) begin
              glyph = GLYPH_YO_UP;
            end else if (lead_q == LEAD_D1 && value_i[5:0] == IDX_YO_LOW) begin
              glyph = GLYPH_YO_LOW;
            end
            s1 = show_fn(col_q, line_q);
            plan_o.frm[0] = '{data: glyph, rs: 1'b1};
            n = 3'd1;
            if (s1.wrap) begin
              plan_o.frm[1] = '{data: s1.cmd, rs: 1'b0};
              n = 3'd2;
            end
            col_d  = s1.col;
            line_d = s1.line;
          end
        end else if (value_i == LEAD_BYTE_D0) begin
          lead_d = LEAD_D0;
        end else if (value_i == LEAD_BYTE_D1) begin
          lead_d = LEAD_D1;
        end else begin
          s1 = show_fn(col_q, line_q);
          plan_o.frm[0] = '{data: value_i, rs: 1'b1};
          n = 3'd1;
          if (s1.wrap) begin
            plan_o.frm[1] = '{data: s1.cmd, rs: 1'b0};
            n = 3'd2;
          end
          col_d  = s1.col;
          line_d = s1.line;
        end
      end
      KIND_CMD: begin
        plan_o.frm[0] = '{data: value_i, rs: 1'b0};
        n = 3'd1;
      end
      KIND_PLACE: begin
        col_d  = column_i;
        line_d = row_c[1:0];
        plan_o.frm[0] = '{data: addr_cmd(column_i, row_c[1:0]), rs: 1'b0};
        n = 3'd1;
      end
      KIND_CLEAR: begin
        col_d  = 6'd0;
        line_d = 2'd0;
        plan_o.frm[0] = '{data: CMD_CLEAR, rs: 1'b0};
        n = 3'd1;
      end
      KIND_INIT: begin
        lead_d = LEAD_NONE;
        plan_o.frm[0] = '{data: CMD_INIT_A, rs: 1'b0};
        plan_o.frm[1] = '{data: CMD_INIT_B, rs: 1'b0};
        plan_o.frm[2] = '{data: CMD_INIT_C, rs: 1'b0};
        n = 3'd3;
      end
      default: begin
        n = 3'd0;
      end
    endcase
    plan_o.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= LEAD_NONE;
      col_q  <= 6'd0;
      line_q <= 2'd0;
    end else if (accept_i) begin
      lead_q <= lead_d;
      col_q  <= col_d;
      line_q <= line_d;
    end
  end

endmodule

// ===== hw/rtl/clcd_serializer.sv =====
// Holds one planned operation and sends its frames as expander bytes, one per
// cycle when not stalled, through an output register. Depends on clcd_pkg.
module clcd_serializer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  clcd_pkg::plan_t plan_i,
  input  logic            backlight_i,
  input  logic            out_stall_i,
  output logic            ready_o,
  output logic            out_valid_o,
  output logic [7:0]      bus_byte_o,
  output logic            frame_end_o,
  output logic            last_o
);
  import clcd_pkg::*;

  plan_t      job_q;
  logic       job_valid_q;
  logic [1:0] fidx_q;
  logic [1:0] phase_q;
  logic       out_valid_q;
  logic [7:0] byte_q;
  logic       fend_q;
  logic       last_q;

  frame_t     cur;
  logic       out_free;
  logic       emit;
  logic       last_byte;
  logic       job_done;
  logic [3:0] nib;
  logic [7:0] byte_d;

  assign cur       = job_q.frm[fidx_q];
  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit      = job_valid_q && out_free;
  assign last_byte = ({1'b0, fidx_q} == (job_q.count - 3'd1)) && (phase_q == 2'd3);
  assign job_done  = emit && last_byte;
  assign ready_o   = !job_valid_q || job_done;
  assign nib       = phase_q[1] ? cur.data[3:0] : cur.data[7:4];
  assign byte_d    = {nib, backlight_i, !phase_q[0], 1'b0, cur.rs};

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      job_q <= plan_i;
    end
    if (emit) begin
      byte_q <= byte_d;
      fend_q <= (phase_q == 2'd3);
      last_q <= last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      fidx_q      <= 2'd0;
      phase_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        job_valid_q <= (plan_i.count != 3'd0);
        fidx_q      <= 2'd0;
        phase_q     <= 2'd0;
      end else if (emit) begin
        if (job_done) begin
          job_valid_q <= 1'b0;
        end
        phase_q <= phase_q + 2'd1;
        if (phase_q == 2'd3) begin
          fidx_q <= fidx_q + 2'd1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign bus_byte_o  = byte_q;
  assign frame_end_o = fend_q;
  assign last_o      = last_q;

endmodule

// ===== hw/rtl/char_lcd_utf8_cyrillic_i2c_writer_top.sv =====
// Top level of the character display writer: configuration registers, planner and
// byte serializer. Depends on clcd_pkg, clcd_planner and clcd_serializer.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o   kind_i value_i column_i row_i
//   out      output     out_valid_o / out_stall_i bus_byte_o bus_address_o
//                                                 frame_end_o last_o
//   cfg      input      cfg_we_i                  cfg_index_i cfg_data_i
//
// Each controller byte goes out as four expander bytes, so a request sends 4, 8, 12
// or 16, one per cycle while not stalled; one with no result sends none.
// The next request is accepted in the cycle the last byte of the current one moves
// into the output register. Reset is asynchronous and needs no clearing pass.
// A stall on the output holds the output register and then the job register.
module char_lcd_utf8_cyrillic_i2c_writer_top #(
  parameter int COLUMNS = 20,
  parameter int LINES   = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] kind_i,
  input  logic [7:0] value_i,
  input  logic [5:0] column_i,
  input  logic [2:0] row_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] bus_byte_o,
  output logic [7:0] bus_address_o,
  output logic       frame_end_o,
  output logic       last_o,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_index_i,
  input  logic [6:0] cfg_data_i
);
  import clcd_pkg::*;

  localparam logic [0:0] REG_ADDRESS   = 1'd0;
  localparam logic [0:0] REG_BACKLIGHT = 1'd1;

  logic [6:0] dev_addr_q;
  logic       backlight_q;
  logic       ready;
  logic       accept;
  plan_t      plan;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= 7'd39;
      backlight_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ADDRESS:   dev_addr_q  <= cfg_data_i;
        REG_BACKLIGHT: backlight_q <= cfg_data_i[0];
        default:       dev_addr_q  <= dev_addr_q;
      endcase
    end
  end

  assign in_stall_o    = !ready;
  assign accept        = in_valid_i && ready;
  assign bus_address_o = {dev_addr_q, 1'b0};

  clcd_planner #(
    .COLUMNS(COLUMNS),
    .LINES  (LINES)
  ) u_planner (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .kind_i  (kind_i),
    .value_i (value_i),
    .column_i(column_i),
    .row_i   (row_i),
    .plan_o  (plan)
  );

  clcd_serializer u_serializer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .plan_i     (plan),
    .backlight_i(backlight_q),
    .out_stall_i(out_stall_i),
    .ready_o    (ready),
    .out_valid_o(out_valid_o),
    .bus_byte_o (bus_byte_o),
    .frame_end_o(frame_end_o),
    .last_o     (last_o)
  );

endmodule

// ===== hw/rtl/clcd_checker.sv =====
// Port-level checks for the character display writer, bound to its top level.
// Depends only on the top level's ports.
module clcd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] bus_byte_o,
  input logic [7:0] bus_address_o,
  input logic       frame_end_o,
  input logic       last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bus_byte_o)
      && $stable(frame_end_o) && $stable(last_o) && $stable(bus_address_o))
    else $error("stalled output changed");

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> frame_end_o)
    else $error("last byte is not a frame end");

  a_strobe_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !bus_byte_o[1] && !(frame_end_o && bus_byte_o[2]))
    else $error("bad expander byte");

  a_strobe_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && bus_byte_o[2] |=> out_valid_o)
    else $error("enable byte not followed at once");

endmodule

bind char_lcd_utf8_cyrillic_i2c_writer_top clcd_checker u_checker (.*);

// ===== tb/char_lcd_utf8_cyrillic_i2c_writer_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the character display writer: a directed table and random
// display requests, checked byte by byte against a predictor of the expander stream.
// Depends on clcd_pkg and char_lcd_utf8_cyrillic_i2c_writer_top.
module char_lcd_utf8_cyrillic_i2c_writer_top_test;
  import clcd_pkg::*;

  localparam int COLUMNS = 20;
  localparam int LINES = 4;
  localparam logic [2:0] KIND_SPARE_A = 3'd5;
  localparam logic [2:0] KIND_SPARE_C = 3'd7;
  localparam logic [0:0] REG_DEVICE_ADDRESS = 1'b0;
  localparam logic [0:0] REG_BACKLIGHT = 1'b1;
  localparam logic [7:0] RESET_BUS_ADDRESS = 8'h4E;
  localparam int DRAIN_CYCLES = 24;
  localparam int LONG_HOLD = 300;
  localparam int MAX_REPORTS = 50;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic [7:0] bus_address;
    logic       frame_end;
    logic       last;
  } bus_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  value;
    logic [5:0]  column;
    logic [2:0]  row;
    logic        typed;
    logic [31:0] typed_bytes;
  } directed_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [2:0] kind_i = '0;
  logic [7:0] value_i = '0;
  logic [5:0] column_i = '0;
  logic [2:0] row_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] bus_byte_o;
  logic [7:0] bus_address_o;
  logic       frame_end_o;
  logic       last_o;
  logic       cfg_we_i = 1'b0;
  logic [0:0] cfg_index_i = '0;
  logic [6:0] cfg_data_i = '0;

  bus_word_t expected_bus[$];
  bus_word_t staged_bus[$];
  int        fail_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_requests = 0;
  int        hold_served = 0;
  int        hold_left = 0;

  logic [6:0] lcd_address = 7'd39;
  logic       lcd_backlight = 1'b1;
  lead_e      held_lead = LEAD_NONE;
  logic [5:0] lcd_column = '0;
  logic [1:0] lcd_line = '0;

  directed_row_t directed_rows [26] = '{
    '{KIND_CLEAR, 8'h00, 6'd0,  3'd0, 1'b1, 32'h0C081C18},
    '{KIND_CMD,   8'hFF, 6'd0,  3'd0, 1'b1, 32'hFCF8FCF8},
    '{KIND_CHAR,  8'h41, 6'd0,  3'd0, 1'b1, 32'h4D491D19},
    '{KIND_CHAR,  8'h00, 6'd63, 3'd7, 1'b0, 32'h0},
    '{KIND_CHAR,  LEAD_BYTE_D0, 6'd0, 3'd0, 1'b0, 32'h0},
    '{KIND_CHAR,  8'h81, 6'd0,  3'd0, 1'b0, 32'h0},
    '{KIND_CHAR,  LEAD_BYTE_D1, 6'd0, 3'd0, 1'b0, 32'h0},
    '{KIND_CHAR,  8'h91, 6'd0,  3'd0, 1'b0, 32'h0},
    '{KIND_CHAR,  LEAD_BYTE_D0, 6'd0, 3'd0, 1'b0, 32'h0},
    '{KIND_CHAR,  8'h80, 6'd0,  3'd0, 1'b0, 32'h0},
    '{KIND_CHAR,  LEAD_BYTE_D1, 6'd0, 3'd0, 1'b0, 32'h0},
    '{KIND_CHAR,  8'hBF, 6'd0,  3'd0, 1'b0, 32'h0},
    '{KIND_CHAR,  LEAD_BYTE_D0, 6'd0, 3'd0, 1'b0, 32'h0},
    '{KIND_CHAR,  LEAD_BYTE_D1, 6'd0, 3'd0, 1'b0, 32'h0},
    '{KIND_CHAR,  LEAD_BYTE_D0, 6'd0, 3'd0, 1'b0, 32'h0},
    '{KIND_CMD,   CMD_CLEAR, 6'd0, 3'd0, 1'b1, 32'h0C081C18},
    '{KIND_CHAR,  CONT_END, 6'd0, 3'd0, 1'b0, 32'h0},
    '{KIND_CHAR,  LEAD_BYTE_D1, 6'd0, 3'd0, 1'b0, 32'h0},
    '{KIND_INIT,  8'h00, 6'd0,  3'd0, 1'b0, 32'h0},
    '{KIND_CHAR,  8'h85, 6'd0,  3'd0, 1'b0, 32'h0},
    '{KIND_PLACE, 8'h00, 6'd39, 3'd7, 1'b0, 32'h0},
    '{KIND_CHAR,  8'h41, 6'd0,  3'd0, 1'b0, 32'h0},
    '{KIND_PLACE, 8'h00, 6'd63, 3'd2, 1'b0, 32'h0},
    '{KIND_SPARE_A, 8'hFF, 6'd63, 3'd7, 1'b0, 32'h0},
    '{KIND_PLACE, 8'h00, 6'd19, 3'd3, 1'b0, 32'h0},
    '{KIND_CHAR,  8'h7E, 6'd0,  3'd0, 1'b0, 32'h0}
  };

  char_lcd_utf8_cyrillic_i2c_writer_top #(
    .COLUMNS(COLUMNS),
    .LINES  (LINES)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .value_i      (value_i),
    .column_i     (column_i),
    .row_i        (row_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .bus_byte_o   (bus_byte_o),
    .bus_address_o(bus_address_o),
    .frame_end_o  (frame_end_o),
    .last_o       (last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  function automatic void emit_frame(input logic [7:0] data, input logic rs);
    logic [7:0] base;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] addr;
    base = {4'b0000, lcd_backlight, 2'b00, rs};
    hi = data & 8'hF0;
    lo = {data[3:0], 4'b0000};
    addr = {lcd_address, 1'b0};
    staged_bus.push_back('{hi | base | 8'h04, addr, 1'b0, 1'b0});
    staged_bus.push_back('{hi | base, addr, 1'b0, 1'b0});
    staged_bus.push_back('{lo | base | 8'h04, addr, 1'b0, 1'b0});
    staged_bus.push_back('{lo | base, addr, 1'b1, 1'b0});
  endfunction

  function automatic void move_cursor(input int col, input int line);
    int offset;
    if (line >= LINES) begin
      line = LINES - 1;
    end
    lcd_column = col[5:0];
    lcd_line = line[1:0];
    offset = (lcd_line[0] ? int'(LINE1_OFFSET) : 0) + (lcd_line[1] ? COLUMNS : 0);
    emit_frame(CMD_SET_ADDR | 8'((int'(lcd_column) + offset) & 8'hFF), 1'b0);
  endfunction

  function automatic void display_glyph(input logic [7:0] glyph);
    emit_frame(glyph, 1'b1);
    if (int'(lcd_column) + 1 >= COLUMNS) begin
      move_cursor(0, (int'(lcd_line) + 1 >= LINES) ? 0 : int'(lcd_line) + 1);
    end else begin
      lcd_column = lcd_column + 6'd1;
    end
  endfunction

  function automatic void decode_char(input logic [7:0] v);
    logic       second_lead;
    logic [5:0] idx;
    if (held_lead != LEAD_NONE) begin
      second_lead = (held_lead == LEAD_D1);
      idx = v[5:0];
      if (v >= CONT_END || v < CONT_LOW) begin
        display_glyph(second_lead ? LEAD_BYTE_D1 : LEAD_BYTE_D0);
        display_glyph(v);
      end else if (!second_lead && idx == IDX_YO_UP) begin
        display_glyph(GLYPH_YO_UP);
      end else if (second_lead && idx == IDX_YO_LOW) begin
        display_glyph(GLYPH_YO_LOW);
      end else begin
        display_glyph(CYR_MAP[idx]);
      end
      held_lead = LEAD_NONE;
    end else if (v == LEAD_BYTE_D0) begin
      held_lead = LEAD_D0;
    end else if (v == LEAD_BYTE_D1) begin
      held_lead = LEAD_D1;
    end else begin
      display_glyph(v);
    end
  endfunction

  function automatic void predict_bus_bytes(input logic [2:0] kind, input logic [7:0] value,
                                            input logic [5:0] column, input logic [2:0] row);
    case (kind)
      KIND_CHAR: begin
        decode_char(value);
      end
      KIND_CMD: begin
        emit_frame(value, 1'b0);
      end
      KIND_PLACE: begin
        move_cursor(int'(column), int'(row));
      end
      KIND_CLEAR: begin
        lcd_column = '0;
        lcd_line = '0;
        emit_frame(CMD_CLEAR, 1'b0);
      end
      KIND_INIT: begin
        emit_frame(CMD_INIT_A, 1'b0);
        emit_frame(CMD_INIT_B, 1'b0);
        emit_frame(CMD_INIT_C, 1'b0);
        held_lead = LEAD_NONE;
      end
      default: begin
      end
    endcase
    if (staged_bus.size() > 0) begin
      staged_bus[staged_bus.size() - 1].last = 1'b1;
    end
  endfunction

  task automatic send_request(input logic [2:0] kind, input logic [7:0] value,
                              input logic [5:0] column, input logic [2:0] row,
                              input logic typed = 1'b0, input logic [31:0] typed_bytes = '0);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    value_i <= value;
    column_i <= column;
    row_i <= row;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    staged_bus.delete();
    predict_bus_bytes(kind, value, column, row);
    if (typed) begin
      staged_bus.delete();
      for (int i = 0; i < 4; i++) begin
        staged_bus.push_back('{typed_bytes[31 - 8 * i -: 8], RESET_BUS_ADDRESS,
                               i == 3, i == 3});
      end
    end
    foreach (staged_bus[i]) begin
      expected_bus.push_back(staged_bus[i]);
    end
  endtask

  task automatic wait_for_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_bus.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_settings(input logic [6:0] address, input logic backlight);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_DEVICE_ADDRESS;
    cfg_data_i <= address;
    @(negedge clk_i);
    cfg_index_i <= REG_BACKLIGHT;
    cfg_data_i <= {6'($urandom_range(63)), backlight};
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    lcd_address = address;
    lcd_backlight = backlight;
  endtask

  task automatic send_random_burst(input int count);
    int         sent;
    int         pick;
    logic [5:0] col;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      col = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(39));
      if (pick < 45) begin
        send_request(KIND_CHAR, $urandom_range(1) ? LEAD_BYTE_D1 : LEAD_BYTE_D0,
                     6'($urandom), 3'($urandom));
        send_request(KIND_CHAR, CONT_LOW | 8'($urandom_range(63)), 6'($urandom), 3'($urandom));
        sent += 2;
      end else if (pick < 63) begin
        send_request(KIND_CHAR, 8'($urandom), 6'($urandom), 3'($urandom));
        sent += 1;
      end else if (pick < 70) begin
        send_request(KIND_CHAR, $urandom_range(1) ? LEAD_BYTE_D1 : LEAD_BYTE_D0,
                     6'($urandom), 3'($urandom));
        send_request(KIND_CHAR, 8'($urandom), 6'($urandom), 3'($urandom));
        sent += 2;
      end else if (pick < 79) begin
        send_request(KIND_CMD, 8'($urandom), 6'($urandom), 3'($urandom));
        sent += 1;
      end else if (pick < 90) begin
        send_request(KIND_PLACE, 8'($urandom), col, 3'($urandom));
        sent += 1;
      end else if (pick < 94) begin
        send_request(KIND_CLEAR, 8'($urandom), 6'($urandom), 3'($urandom));
        sent += 1;
      end else if (pick < 97) begin
        send_request(KIND_INIT, 8'($urandom), 6'($urandom), 3'($urandom));
        sent += 1;
      end else begin
        send_request(3'($urandom_range(KIND_SPARE_A, KIND_SPARE_C)), 8'($urandom),
                     6'($urandom), 3'($urandom));
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_bus
    bus_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bus.size() == 0) begin
        report_mismatch($sformatf("unexpected bus byte %02h", bus_byte_o));
      end else begin
        want = expected_bus.pop_front();
        if (bus_byte_o !== want.bus_byte) begin
          report_mismatch($sformatf("bus_byte %02h, want %02h", bus_byte_o, want.bus_byte));
        end
        if (bus_address_o !== want.bus_address) begin
          report_mismatch($sformatf("bus_address %02h, want %02h", bus_address_o,
                                    want.bus_address));
        end
        if (frame_end_o !== want.frame_end) begin
          report_mismatch($sformatf("frame_end %b, want %b", frame_end_o, want.frame_end));
        end
        if (last_o !== want.last) begin
          report_mismatch($sformatf("last %b, want %b", last_o, want.last));
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("char_lcd_utf8_cyrillic_i2c_writer_top_test: FAIL");
    $finish;
  end

  initial begin
    send_idle_pct = 35;
    recv_idle_pct = 52;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].column,
                   directed_rows[i].row, directed_rows[i].typed, directed_rows[i].typed_bytes);
    end
    wait_for_drain();

    write_settings(7'd0, 1'b0);
    send_random_burst(60);
    wait_for_drain();

    send_idle_pct = 52;
    recv_idle_pct = 35;
    write_settings(7'd127, 1'b1);
    send_random_burst(60);
    wait_for_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_settings(7'($urandom), 1'b0);
    send_random_burst(20);
    hold_requests++;
    send_random_burst(20);
    wait_for_drain();
    send_random_burst(20);
    wait_for_drain();

    if (fail_count == 0) begin
      $display("char_lcd_utf8_cyrillic_i2c_writer_top_test: PASS");
    end else begin
      $display("char_lcd_utf8_cyrillic_i2c_writer_top_test: FAIL");
    end
    $finish;
  end

endmodule
